// File: hdl/tas_pkg.sv
// Shared types and constants for the turning-angle track segmenter.
// Used by the controller, the datapath, the multiplier and the top level.
package tas_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int THR_W           = 16;
   localparam int DIGIT_W         = 16;

   localparam logic [THR_W-1:0] THR_RESET = 16'd57870;

   localparam logic [1:0] SEEN_NONE = 2'd0;
   localparam logic [1:0] SEEN_ONE  = 2'd1;
   localparam logic [1:0] SEEN_MANY = 2'd2;

   // multiplier digits needed for a squared-length operand
   function automatic int tas_digits(input int coord_width);
      return (2 * coord_width + 2 + DIGIT_W - 1) / DIGIT_W;
   endfunction

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DIFF,
      ST_LOAD,
      ST_RUN,
      ST_STORE,
      ST_DECIDE,
      ST_EMIT_FIRST,
      ST_EMIT_MID,
      ST_FINISH,
      ST_EMIT_FINAL
   } tas_state_type;

   typedef enum logic [3:0] {
      OP_D1XX,
      OP_D1YY,
      OP_D2XX,
      OP_D2YY,
      OP_DOTX,
      OP_DOTY,
      OP_DOTSQ,
      OP_THRL1,
      OP_RHS
   } tas_op_type;

   localparam tas_op_type OP_LAST = OP_RHS;

   typedef enum logic [1:0] {
      OSEL_FIRST,
      OSEL_MID,
      OSEL_FINAL
   } tas_osel_type;

   typedef struct packed {
      logic         capture;
      logic         diff_load;
      logic         mul_load;
      logic         mul_step;
      logic         store;
      tas_op_type   op;
      logic         out_load;
      tas_osel_type osel;
      logic         shift;
   } tas_cmd_type;

   typedef struct packed {
      logic eot;
      logic turn;
   } tas_sts_type;

endpackage

// File: hdl/tas_mul.sv
// Digit-serial unsigned multiplier, one 16-bit digit of b per step, MSB first.
// Depends on tas_pkg for the digit width.
module tas_mul #(
   parameter int A_WIDTH = 50,
   parameter int B_WIDTH = 48
) (
   input  logic                       clock,
   input  logic                       load,
   input  logic                       step,
   input  logic [A_WIDTH-1:0]         a_op,
   input  logic [B_WIDTH-1:0]         b_op,
   output logic [A_WIDTH+B_WIDTH-1:0] product
);
   import tas_pkg::*;

   localparam int PW = A_WIDTH + B_WIDTH;

   logic [A_WIDTH-1:0]         a_ff;
   logic [B_WIDTH-1:0]         b_ff, b_in;
   logic [PW-1:0]              acc_ff, acc_in;
   logic [DIGIT_W-1:0]         digit;
   logic [A_WIDTH+DIGIT_W-1:0] pp;

   assign digit  = b_ff[B_WIDTH-1 -: DIGIT_W];
   assign pp     = a_ff * digit;
   assign acc_in = (acc_ff << DIGIT_W) + PW'(pp);
   assign b_in   = b_ff << DIGIT_W;

   always_ff @(posedge clock) begin
      if (load) begin
         a_ff   <= a_op;
         b_ff   <= b_op;
         acc_ff <= '0;
      end else if (step) begin
         b_ff   <= b_in;
         acc_ff <= acc_in;
      end
   end

   assign product = acc_ff;

endmodule

// File: hdl/tas_dp.sv
// Datapath: point history, direction magnitudes, length/dot products, turn test
// and the result register. Depends on tas_pkg and tas_mul.
module tas_dp #(
   parameter int COORD_WIDTH = tas_pkg::COORD_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic signed [COORD_WIDTH-1:0]    req_point_x,
   input  logic signed [COORD_WIDTH-1:0]    req_point_y,
   input  logic                             req_end_of_track,
   input  logic                             csr_valid,
   input  logic [tas_pkg::THR_W-1:0]        csr_cos_sq_threshold,
   input  tas_pkg::tas_cmd_type             cmd,
   output tas_pkg::tas_sts_type             sts,
   output logic signed [COORD_WIDTH-1:0]    rsp_kept_x,
   output logic signed [COORD_WIDTH-1:0]    rsp_kept_y,
   output logic                             rsp_track_final,
   output logic                             rsp_run_last
);
   import tas_pkg::*;

   localparam int W    = COORD_WIDTH;
   localparam int DW   = W + 1;
   localparam int LW   = 2 * W + 2;
   localparam int SDW  = 2 * W + 3;
   localparam int NDIG = tas_digits(COORD_WIDTH);
   localparam int AW   = LW + THR_W;
   localparam int BW   = NDIG * DIGIT_W;
   localparam int PW   = AW + BW;
   localparam int CW   = 2 * LW + THR_W;

   function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] d);
      logic signed [DW-1:0] n;
      n = -d;
      return d[DW-1] ? n : d;
   endfunction

   logic signed [W-1:0]   older_x_ff, older_y_ff, mid_x_ff, mid_y_ff, new_x_ff, new_y_ff;
   logic                  eot_ff;
   logic [THR_W-1:0]      thr_ff;
   logic [DW-1:0]         m1x_ff, m1y_ff, m2x_ff, m2y_ff;
   logic                  n1x_ff, n1y_ff, n2x_ff, n2y_ff;
   logic [LW-1:0]         l1_ff, l1_in, l2_ff, l2_in;
   logic signed [SDW-1:0] dot_ff, dot_in;
   logic [2*LW-1:0]       dsq_ff, dsq_in;
   logic [AW-1:0]         tl_ff, tl_in;
   logic [CW-1:0]         rhs_ff, rhs_in;

   logic signed [DW-1:0]  d1x, d1y, d2x, d2y;
   logic signed [SDW-1:0] pv, pv_signed, dot_abs;
   logic [LW-1:0]         dmag;
   logic [AW-1:0]         a_sel;
   logic [BW-1:0]         b_sel;
   logic [PW-1:0]         prod;
   logic [CW-1:0]         lhs;
   logic                  len_nz, dot_le0;

   // directions: d1 = middle - older, d2 = new - middle
   assign d1x = $signed({mid_x_ff[W-1], mid_x_ff}) - $signed({older_x_ff[W-1], older_x_ff});
   assign d1y = $signed({mid_y_ff[W-1], mid_y_ff}) - $signed({older_y_ff[W-1], older_y_ff});
   assign d2x = $signed({new_x_ff[W-1], new_x_ff}) - $signed({mid_x_ff[W-1], mid_x_ff});
   assign d2y = $signed({new_y_ff[W-1], new_y_ff}) - $signed({mid_y_ff[W-1], mid_y_ff});

   assign dot_abs = dot_ff[SDW-1] ? -dot_ff : dot_ff;
   assign dmag    = dot_abs[LW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_cos_sq_threshold;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         new_x_ff <= req_point_x;
         new_y_ff <= req_point_y;
         eot_ff   <= req_end_of_track;
      end
      if (cmd.shift) begin
         older_x_ff <= mid_x_ff;
         older_y_ff <= mid_y_ff;
         mid_x_ff   <= new_x_ff;
         mid_y_ff   <= new_y_ff;
      end
      if (cmd.diff_load) begin
         m1x_ff <= mag_of(d1x);
         m1y_ff <= mag_of(d1y);
         m2x_ff <= mag_of(d2x);
         m2y_ff <= mag_of(d2y);
         n1x_ff <= d1x[DW-1];
         n1y_ff <= d1y[DW-1];
         n2x_ff <= d2x[DW-1];
         n2y_ff <= d2y[DW-1];
      end
   end

   // operand selection for the shared multiplier
   always_comb begin
      a_sel = '0;
      b_sel = '0;
      unique case (cmd.op)
         OP_D1XX: begin
            a_sel = AW'(m1x_ff);
            b_sel = BW'(m1x_ff);
         end
         OP_D1YY: begin
            a_sel = AW'(m1y_ff);
            b_sel = BW'(m1y_ff);
         end
         OP_D2XX: begin
            a_sel = AW'(m2x_ff);
            b_sel = BW'(m2x_ff);
         end
         OP_D2YY: begin
            a_sel = AW'(m2y_ff);
            b_sel = BW'(m2y_ff);
         end
         OP_DOTX: begin
            a_sel = AW'(m1x_ff);
            b_sel = BW'(m2x_ff);
         end
         OP_DOTY: begin
            a_sel = AW'(m1y_ff);
            b_sel = BW'(m2y_ff);
         end
         OP_DOTSQ: begin
            a_sel = AW'(dmag);
            b_sel = BW'(dmag);
         end
         OP_THRL1: begin
            a_sel = AW'(l1_ff);
            b_sel = BW'(thr_ff);
         end
         OP_RHS: begin
            a_sel = tl_ff;
            b_sel = BW'(l2_ff);
         end
         default: begin
            a_sel = '0;
            b_sel = '0;
         end
      endcase
   end

   tas_mul #(
      .A_WIDTH (AW),
      .B_WIDTH (BW)
   ) u_mul (
      .clock   (clock),
      .load    (cmd.mul_load),
      .step    (cmd.mul_step),
      .a_op    (a_sel),
      .b_op    (b_sel),
      .product (prod)
   );

   // component product of the dot, before the sign of the two factors is applied
   assign pv = $signed(prod[SDW-1:0]);

   always_comb begin
      l1_in     = l1_ff;
      l2_in     = l2_ff;
      dot_in    = dot_ff;
      dsq_in    = dsq_ff;
      tl_in     = tl_ff;
      rhs_in    = rhs_ff;
      pv_signed = ((cmd.op == OP_DOTX) ? (n1x_ff ^ n2x_ff) : (n1y_ff ^ n2y_ff)) ? -pv : pv;
      unique case (cmd.op)
         OP_D1XX:  l1_in  = prod[LW-1:0];
         OP_D1YY:  l1_in  = l1_ff + prod[LW-1:0];
         OP_D2XX:  l2_in  = prod[LW-1:0];
         OP_D2YY:  l2_in  = l2_ff + prod[LW-1:0];
         OP_DOTX:  dot_in = pv_signed;
         OP_DOTY:  dot_in = dot_ff + pv_signed;
         OP_DOTSQ: dsq_in = prod[2*LW-1:0];
         OP_THRL1: tl_in  = prod[AW-1:0];
         OP_RHS:   rhs_in = prod[CW-1:0];
         default:  rhs_in = rhs_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         l1_ff  <= l1_in;
         l2_ff  <= l2_in;
         dot_ff <= dot_in;
         dsq_ff <= dsq_in;
         tl_ff  <= tl_in;
         rhs_ff <= rhs_in;
      end
   end

   // a zero-length direction never gives a turn
   assign len_nz   = (l1_ff != '0) && (l2_ff != '0);
   assign dot_le0  = dot_ff[SDW-1] || (dot_ff == '0);
   assign lhs      = {dsq_ff, THR_W'(0)};
   assign sts.turn = len_nz && (dot_le0 || (lhs <= rhs_ff));
   assign sts.eot  = eot_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         unique case (cmd.osel)
            OSEL_FIRST: begin
               rsp_kept_x      <= new_x_ff;
               rsp_kept_y      <= new_y_ff;
               rsp_track_final <= 1'b0;
               rsp_run_last    <= !eot_ff;
            end
            OSEL_MID: begin
               rsp_kept_x      <= mid_x_ff;
               rsp_kept_y      <= mid_y_ff;
               rsp_track_final <= 1'b0;
               rsp_run_last    <= !eot_ff;
            end
            OSEL_FINAL: begin
               rsp_kept_x      <= new_x_ff;
               rsp_kept_y      <= new_y_ff;
               rsp_track_final <= 1'b1;
               rsp_run_last    <= 1'b1;
            end
            default: begin
               rsp_kept_x      <= new_x_ff;
               rsp_kept_y      <= new_y_ff;
               rsp_track_final <= 1'b1;
               rsp_run_last    <= 1'b1;
            end
         endcase
      end
   end

endmodule

// File: hdl/tas_ctrl.sv
// Controller: request/response handshakes, point count and the sequence of
// multiplier operations for the turn test. Depends on tas_pkg.
module tas_ctrl #(
   parameter int COORD_WIDTH = tas_pkg::COORD_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tas_pkg::tas_sts_type sts,
   output tas_pkg::tas_cmd_type cmd
);
   import tas_pkg::*;

   localparam int NDIG = tas_digits(COORD_WIDTH);
   localparam int DGW  = $clog2(NDIG);

   tas_state_type  state_ff, state_in;
   tas_op_type     op_ff, op_in;
   logic [DGW-1:0] dig_ff, dig_in;
   logic [1:0]     seen_ff, seen_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_D1XX;
         dig_ff   <= '0;
         seen_ff  <= SEEN_NONE;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         dig_ff   <= dig_in;
         seen_ff  <= seen_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      dig_in   = dig_ff;
      seen_in  = seen_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (seen_ff == SEEN_NONE) begin
               state_in = ST_EMIT_FIRST;
            end else if (seen_ff == SEEN_ONE) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            op_in    = OP_D1XX;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            dig_in   = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (dig_ff == DGW'(NDIG - 1)) begin
               state_in = ST_STORE;
            end else begin
               dig_in = dig_ff + 1'b1;
            end
         end
         ST_STORE: begin
            if (op_ff == OP_LAST) begin
               state_in = ST_DECIDE;
            end else begin
               op_in    = tas_op_type'(op_ff + 4'd1);
               state_in = ST_LOAD;
            end
         end
         ST_DECIDE: begin
            state_in = sts.turn ? ST_EMIT_MID : ST_FINISH;
         end
         ST_EMIT_FIRST, ST_EMIT_MID: begin
            if (rsp_ready) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.eot) begin
               seen_in  = SEEN_NONE;
               state_in = ST_EMIT_FINAL;
            end else begin
               seen_in  = (seen_ff == SEEN_NONE) ? SEEN_ONE : SEEN_MANY;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_FINAL: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.op    = op_ff;
      cmd.osel  = OSEL_FIRST;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DISPATCH: begin
            cmd.out_load = (seen_ff == SEEN_NONE);
            cmd.osel     = OSEL_FIRST;
         end
         ST_DIFF:  cmd.diff_load = 1'b1;
         ST_LOAD:  cmd.mul_load  = 1'b1;
         ST_RUN:   cmd.mul_step  = 1'b1;
         ST_STORE: cmd.store     = 1'b1;
         ST_DECIDE: begin
            cmd.out_load = sts.turn;
            cmd.osel     = OSEL_MID;
         end
         ST_EMIT_FIRST, ST_EMIT_MID, ST_EMIT_FINAL: begin
            rsp_valid = 1'b1;
         end
         ST_FINISH: begin
            // a closing point goes out; otherwise advance the point history
            cmd.out_load = sts.eot;
            cmd.osel     = OSEL_FINAL;
            cmd.shift    = !sts.eot;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DISPATCH))
      else $error("accepted request not dispatched");

   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      (seen_ff == SEEN_NONE) || (seen_ff == SEEN_ONE) || (seen_ff == SEEN_MANY))
      else $error("point count out of range");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (dig_ff <= DGW'(NDIG - 1)))
      else $error("multiplier digit count overrun");

   a_mid_on_turn: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |=> ((state_ff == ST_EMIT_MID) == $past(sts.turn)))
      else $error("middle point emitted without a turn");

endmodule

// File: hdl/turning_angle_track_segmenter_top.sv
// Sequence: the first point of a track is loaded for a response; the second only advances
// the point history; with two points held, the nine products of the turn test each run
// through D = ceil((2*COORD_WIDTH+2)/16) multiplier digits before the turn decision.
// Throughput: one request at a time; the nine products of the turn test share one
// digit-serial multiplier, which sets the rate. Each response waits for rsp_ready.
// Reset: synchronous, active high; clears the point count and restores the threshold.
module turning_angle_track_segmenter_top #(
   parameter int COORD_WIDTH = tas_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic                          req_end_of_track,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_kept_x,
   output logic signed [COORD_WIDTH-1:0] rsp_kept_y,
   output logic                          rsp_track_final,
   output logic                          rsp_run_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tas_pkg::THR_W-1:0]     csr_cos_sq_threshold
);
   import tas_pkg::*;

   tas_cmd_type cmd;
   tas_sts_type sts;

   // threshold register takes a write in any cycle
   assign csr_ready = 1'b1;

   tas_ctrl #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tas_dp #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_point_x          (req_point_x),
      .req_point_y          (req_point_y),
      .req_end_of_track     (req_end_of_track),
      .csr_valid            (csr_valid),
      .csr_cos_sq_threshold (csr_cos_sq_threshold),
      .cmd                  (cmd),
      .sts                  (sts),
      .rsp_kept_x           (rsp_kept_x),
      .rsp_kept_y           (rsp_kept_y),
      .rsp_track_final      (rsp_track_final),
      .rsp_run_last         (rsp_run_last)
   );

endmodule
